[rtl/mam_pkg.sv]
package mam_pkg;

    // Result kinds as they appear on the out_kind port.
    localparam logic [1:0] KIND_SINGLE = 2'd0;
    localparam logic [1:0] KIND_SYSEX  = 2'd1;
    localparam logic [1:0] KIND_MULTI  = 2'd2;

    // MIDI byte values that the parser treats specially.
    localparam logic [7:0] BYTE_SYSEX_START = 8'hF0;
    localparam logic [7:0] BYTE_MTC_QF      = 8'hF1;
    localparam logic [7:0] BYTE_SONG_POS    = 8'hF2;
    localparam logic [7:0] BYTE_SONG_SEL    = 8'hF3;
    localparam logic [7:0] BYTE_SYSEX_END   = 8'hF7;
    localparam logic [3:0] NIB_PROG_CHANGE  = 4'hC;
    localparam logic [3:0] NIB_CHAN_PRESS   = 4'hD;
    localparam logic [3:0] NIB_SYSTEM       = 4'hF;

    // Depth of the message queue between the parser and the serializer.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One dispatched message: up to three bytes, all of one kind.
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [1:0] last_idx;
        logic [1:0] kind;
    } msg_desc_t;

endpackage

[rtl/mam_front.sv]
module mam_front
    import mam_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    output logic       emit,
    output msg_desc_t  desc
);

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_SYSEX = 2'd1;
    localparam logic [1:0] MODE_ONE   = 2'd2;
    localparam logic [1:0] MODE_TWO   = 2'd3;

    logic [1:0] mode_reg, mode_next;
    logic [1:0] fill_reg, fill_next;
    logic [7:0] s0_reg, s0_next;
    logic [7:0] s1_reg, s1_next;
    logic [7:0] s2_reg, s2_next;
    logic [1:0] need;
    logic [1:0] idx;
    logic [1:0] idx_p1;
    logic       res;

    always_comb
    begin
        mode_next     = mode_reg;
        fill_next     = fill_reg;
        s0_next       = s0_reg;
        s1_next       = s1_reg;
        s2_next       = s2_reg;
        res           = 1'b0;
        desc.byte0    = in_byte;
        desc.byte1    = s1_reg;
        desc.byte2    = in_byte;
        desc.last_idx = 2'd0;
        desc.kind     = KIND_SINGLE;
        need          = (mode_reg == MODE_ONE) ? 2'd2 : 2'd3;
        idx           = fill_reg;
        if ((idx == 2'd0) || (idx >= need))
        begin
            idx = 2'd1;
        end
        idx_p1 = idx + 2'd1;

        if (mode_reg == MODE_SYSEX)
        begin
            if (in_byte == BYTE_SYSEX_END)
            begin
                mode_next = MODE_IDLE;
                fill_next = 2'd0;
            end
            res       = 1'b1;
            desc.kind = KIND_SYSEX;
        end
        else if (in_byte[7])
        begin
            if (in_byte[7:4] != NIB_SYSTEM)
            begin
                if ((in_byte[7:4] == NIB_PROG_CHANGE) || (in_byte[7:4] == NIB_CHAN_PRESS))
                begin
                    mode_next = MODE_ONE;
                end
                else
                begin
                    mode_next = MODE_TWO;
                end
                s0_next   = in_byte;
                fill_next = 2'd1;
            end
            else
            begin
                case (in_byte)
                    BYTE_SYSEX_START:
                    begin
                        mode_next = MODE_SYSEX;
                        fill_next = 2'd0;
                        res       = 1'b1;
                        desc.kind = KIND_SYSEX;
                    end
                    BYTE_MTC_QF, BYTE_SONG_SEL:
                    begin
                        mode_next = MODE_ONE;
                        s0_next   = in_byte;
                        fill_next = 2'd1;
                    end
                    BYTE_SONG_POS:
                    begin
                        mode_next = MODE_TWO;
                        s0_next   = in_byte;
                        fill_next = 2'd1;
                    end
                    BYTE_SYSEX_END:
                    begin
                        mode_next = MODE_IDLE;
                        fill_next = 2'd0;
                        res       = 1'b1;
                    end
                    default:
                    begin
                        res = 1'b1;
                    end
                endcase
            end
        end
        else if ((mode_reg == MODE_ONE) || (mode_reg == MODE_TWO))
        begin
            // Store the data byte; when the message is complete, send it and
            // keep the status byte for running status.
            if (idx == 2'd1)
            begin
                s1_next = in_byte;
            end
            else
            begin
                s2_next = in_byte;
            end
            if (idx_p1 < need)
            begin
                fill_next = idx_p1;
            end
            else
            begin
                res        = 1'b1;
                desc.byte0 = s0_reg;
                desc.kind  = KIND_MULTI;
                if (mode_reg == MODE_ONE)
                begin
                    desc.byte1    = in_byte;
                    desc.last_idx = 2'd1;
                end
                else
                begin
                    desc.last_idx = 2'd2;
                end
                fill_next = 2'd1;
            end
        end
    end

    assign emit = accept & res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            fill_reg <= 2'd0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_reg <= s0_next;
            s1_reg <= s1_next;
            s2_reg <= s2_next;
        end
    end

endmodule

[rtl/mam_queue.sv]
module mam_queue
    import mam_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  msg_desc_t wr_data,
    output logic      full,
    input  logic      rd_en,
    output logic      rd_valid,
    output msg_desc_t rd_data
);

    msg_desc_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/mam_back.sv]
module mam_back
    import mam_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  msg_desc_t  q_data,
    output logic       q_pop,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic [1:0] out_kind,
    output logic       last_of_run
);

    logic       valid_reg, valid_next;
    msg_desc_t  desc_reg, desc_next;
    logic [1:0] idx_reg, idx_next;
    logic       done;

    assign empty       = !valid_reg;
    assign last_of_run = (idx_reg == desc_reg.last_idx);
    assign out_kind    = desc_reg.kind;
    assign done        = valid_reg && pop && last_of_run;
    assign q_pop       = q_valid && (!valid_reg || done);

    always_comb
    begin
        case (idx_reg)
            2'd0:    out_byte = desc_reg.byte0;
            2'd1:    out_byte = desc_reg.byte1;
            default: out_byte = desc_reg.byte2;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        desc_next  = desc_reg;
        idx_next   = idx_reg;
        if (q_pop)
        begin
            valid_next = 1'b1;
            desc_next  = q_data;
            idx_next   = 2'd0;
        end
        else if (done)
        begin
            valid_next = 1'b0;
        end
        else if (valid_reg && pop)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
    end

endmodule

[rtl/midi_message_assembler.sv]
// The first result byte of a transaction is registered in the message queue and then in the
// output stage before it is on the output ports, when the output stage is free.
// Throughput: one input transaction per cycle while the two-entry message queue has room, and
// one result byte per cycle while pop is held; a message holds the output until its last byte.
// Reset (rst_n low, asynchronous) returns the parser to idle, clears the fill count, the queue
// and the output stage; the message store keeps its contents and is always written before use.
module midi_message_assembler
    import mam_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic [1:0] out_kind,
    output logic       last_of_run
);

    // The parser classifies every accepted byte and updates the assembly
    // state in the same cycle. Any byte that causes output turns into one
    // message descriptor, which holds all bytes of the message at once.
    logic      accept;
    logic      emit;
    msg_desc_t front_desc;

    // Queue handshake between the parser and the serializer.
    logic      q_full;
    logic      q_valid;
    logic      q_pop;
    msg_desc_t q_data;

    // The input side stalls only when the queue is full, so a transaction
    // that produces no output is also held back then. This keeps the parser
    // free of any look-ahead on whether the byte will produce output.
    assign full   = q_full;
    assign accept = push && !q_full;

    mam_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .emit    (emit),
        .desc    (front_desc)
    );

    mam_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (emit),
        .wr_data  (front_desc),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_data)
    );

    // The serializer walks through the bytes of one descriptor, one output
    // transaction per byte, and marks the final byte with last_of_run. It
    // loads the next descriptor in the same cycle that the final byte is
    // taken, so back-to-back messages leave no gap on the output.
    mam_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .out_kind    (out_kind),
        .last_of_run (last_of_run)
    );

endmodule
